### src/plq_pkg.sv
// ----------------------------------------------------------------------------
// plq_pkg
// shared types and constants for the packed list core: operation classes,
// the request record passed from the front queue to the back engine
// ----------------------------------------------------------------------------
package plq_pkg;

    // default list capacity
    localparam int CAPACITY_DEFAULT = 16;

    // field widths of the item channels
    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 32;
    localparam int FILL_W  = 5;

    // raw operation codes on the func field
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // decoded operation class
    typedef enum logic [1:0] {
        OP_APPEND,
        OP_FIND,
        OP_REMOVE,
        OP_NONE
    } op_t;

    // request record handed to the back engine
    typedef struct packed {
        logic               valid;
        op_t                op;
        logic [VALUE_W-1:0] value;
    } req_t;

endpackage

### src/plq_front.sv
// ----------------------------------------------------------------------------
// plq_front
// accepts input items, decodes the operation code and holds the requests
// in a short queue so the back engine can stall on its own
// ----------------------------------------------------------------------------
module plq_front import plq_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [FUNC_W-1:0]  s_func,
    input  logic [VALUE_W-1:0] s_value,
    output req_t               req,
    input  logic               req_pop
);

    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] value;
    } qent_t;

    qent_t             q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    op_t               op_dec;
    logic              push;
    logic              pop;

    // classify the operation code
    always_comb begin
        case (s_func)
            FUNC_APPEND: op_dec = OP_APPEND;
            FUNC_FIND:   op_dec = OP_FIND;
            FUNC_REMOVE: op_dec = OP_REMOVE;
            default:     op_dec = OP_NONE;
        endcase
    end

    assign s_tready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop      = req_pop && (cnt_reg != '0);

    // queue head toward the back engine
    assign req.valid = (cnt_reg != '0);
    assign req.op    = q_mem_reg[rd_ptr_reg].op;
    assign req.value = q_mem_reg[rd_ptr_reg].value;

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg].op    <= op_dec;
            q_mem_reg[wr_ptr_reg].value <= s_value;
        end
    end

endmodule

### src/plq_back.sv
// ----------------------------------------------------------------------------
// plq_back
// executes list operations on an entry memory: append at the fill count,
// linear scan for find and remove, then a compaction sweep after a removal
// ----------------------------------------------------------------------------
module plq_back import plq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  req_t              req,
    output logic              req_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_success,
    output logic [FILL_W-1:0] m_fill_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    op_t                op_reg, op_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    logic               ok_reg, ok_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg, out_ok_next;
    logic [FILL_W-1:0]  out_fill_reg, out_fill_next;

    // entry memory, undefined until written
    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [VALUE_W-1:0] wr_data;

    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W-1:0]   idx_inc2;

    assign idx_inc  = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_inc2 = idx_inc + CNT_W'(1);

    // read address: current scan slot, or the slot above during compaction
    assign rd_addr = (state_reg == ST_SHIFT_RD) ? IDX_W'(idx_inc) : idx_reg;

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // engine next-state logic
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_ok_next    = out_ok_reg;
        out_fill_next  = out_fill_reg;
        req_pop        = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req.valid) begin
                    req_pop  = 1'b1;
                    op_next  = req.op;
                    key_next = req.value;
                    idx_next = '0;
                    ok_next  = 1'b0;
                    case (req.op)
                        OP_APPEND: begin
                            if (count_reg < CNT_W'(CAPACITY)) begin
                                wr_en      = 1'b1;
                                wr_addr    = IDX_W'(count_reg);
                                wr_data    = req.value;
                                count_next = count_reg + CNT_W'(1);
                                ok_next    = 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        OP_FIND, OP_REMOVE: begin
                            state_next = (count_reg == '0) ? ST_DONE : ST_SCAN_RD;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (rdata_reg == key_reg) begin
                    if (op_reg == OP_REMOVE) begin
                        if (idx_inc < count_reg) begin
                            state_next = ST_SHIFT_RD;
                        end else begin
                            count_next = count_reg - CNT_W'(1);
                            ok_next    = 1'b1;
                            state_next = ST_DONE;
                        end
                    end else begin
                        ok_next    = 1'b1;
                        state_next = ST_DONE;
                    end
                end else if (idx_inc < count_reg) begin
                    idx_next   = IDX_W'(idx_inc);
                    state_next = ST_SCAN_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT_RD: begin
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                // move the entry above down one slot
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rdata_reg;
                idx_next = IDX_W'(idx_inc);
                if (idx_inc2 < count_reg) begin
                    state_next = ST_SHIFT_RD;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    ok_next    = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_fill_next  = FILL_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        idx_reg      <= idx_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        ok_reg       <= ok_next;
        out_ok_reg   <= out_ok_next;
        out_fill_reg <= out_fill_next;
    end

    assign m_tvalid     = out_valid_reg;
    assign m_success    = out_ok_reg;
    assign m_fill_count = out_fill_reg;

endmodule

### src/packed_list_add_find_remove_core.sv
// sequence: append, unused code or empty-list item pass from idle straight to the done state
// find/remove: a read and a compare state per slot scanned, up to the first match or the fill count
// remove adds a read and a write state per entry moved down in the compaction sweep
// the engine takes no new item until the current one has reached the result register
// a 2-entry request queue keeps input accepting while the engine or result waits, until the queue is full
// reset: synchronous active-low aresetn clears fill count, queue and output valid
// ----------------------------------------------------------------------------
// packed_list_add_find_remove_core
// packed list of signed 32-bit values with append, find and remove-first
// ----------------------------------------------------------------------------
module packed_list_add_find_remove_core import plq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] func, [33:2] value, [39:34] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] success, [5:1] fill_count, [7:6] zero
);

    req_t              req;
    logic              req_pop;
    logic              success;
    logic [FILL_W-1:0] fill_count;

    // front: accept and classify
    plq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tdata[FUNC_W-1:0]),
        .s_value  (s_tdata[FUNC_W+VALUE_W-1:FUNC_W]),
        .req      (req),
        .req_pop  (req_pop)
    );

    // back: execute on the entry memory
    plq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req          (req),
        .req_pop      (req_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_success    (success),
        .m_fill_count (fill_count)
    );

    // pack result fields
    assign m_tdata = {2'b00, fill_count, success};

endmodule

### src/plq_checker.sv
// ----------------------------------------------------------------------------
// plq_checker
// port-level checks of the packed list core, attached by bind
// ----------------------------------------------------------------------------
module plq_checker import plq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    logic [3:0] pending_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // items accepted but not yet answered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (in_acc && !out_acc) begin
            pending_reg <= pending_reg + 4'd1;
        end else if (out_acc && !in_acc) begin
            pending_reg <= pending_reg - 4'd1;
        end
    end

    // no result valid right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // every result answers an accepted item
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 4'd0)
        else $error("result without an accepted item");

    // fill count never exceeds capacity
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (CAPACITY > 31) || (32'(m_tdata[5:1]) <= CAPACITY))
        else $error("fill count above capacity");

    // a waiting input item holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("waiting input item changed");

endmodule

bind packed_list_add_find_remove_core plq_checker #(
    .CAPACITY (CAPACITY)
) u_plq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
